@@ rtl/vva_pkg.sv @@
// ----------------------------------------------------------------------------
// vva_pkg
// Shared types, opcodes and status codes for the three-component vector ALU.
// ----------------------------------------------------------------------------
package vva_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int OPC_W         = 4;
	localparam int STAT_W        = 2;
	localparam int MAG_W         = 2 * DATA_W;
	localparam int FRONT_STAGES  = 3;

	localparam logic [OPC_W-1:0] OP_NEG   = 4'd0;
	localparam logic [OPC_W-1:0] OP_ADD   = 4'd1;
	localparam logic [OPC_W-1:0] OP_SUB   = 4'd2;
	localparam logic [OPC_W-1:0] OP_MUL   = 4'd3;
	localparam logic [OPC_W-1:0] OP_DIV   = 4'd4;
	localparam logic [OPC_W-1:0] OP_SCALE = 4'd5;
	localparam logic [OPC_W-1:0] OP_DIVS  = 4'd6;
	localparam logic [OPC_W-1:0] OP_MAG   = 4'd7;
	localparam logic [OPC_W-1:0] OP_NORM  = 4'd8;
	localparam logic [OPC_W-1:0] OP_DOT   = 4'd9;
	localparam logic [OPC_W-1:0] OP_CROSS = 4'd10;

	localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
	localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
	localparam logic [STAT_W-1:0] ST_DZ  = 2'd2;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		data_t            a_x;
		data_t            a_y;
		data_t            a_z;
		data_t            b_x;
		data_t            b_y;
		data_t            b_z;
		data_t            scalar_in;
	} cmd_t;

	typedef struct packed {
		data_t             r_x;
		data_t             r_y;
		data_t             r_z;
		data_t             scalar_out;
		logic [STAT_W-1:0] status;
	} res_t;

	// sign-magnitude lane; for divides mag holds the dividend magnitude
	typedef struct packed {
		logic              neg;
		logic [MAG_W-1:0]  mag;
		logic              div;
		logic              dz;
		logic              dvs_neg;
		logic [DATA_W-1:0] dvs_mag;
	} lane_t;

	typedef struct packed {
		logic             norm;
		logic             smag;
		logic             vec;
		logic             scl;
		logic             sc_neg;
		logic [MAG_W-1:0] sc_mag;
	} ctl_t;

	typedef struct packed {
		ctl_t        ctl;
		lane_t [2:0] lane;
	} item_t;

endpackage

@@ rtl/vva_front.sv @@
// ----------------------------------------------------------------------------
// vva_front
// Operand select, products, sums and rounding to sign-magnitude (3 stages).
// ----------------------------------------------------------------------------
module vva_front import vva_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  cmd_t                  cmd,
	output logic                  out_valid,
	output item_t                 item,
	output logic [2*DATA_W-1:0]   sumsq
);

	localparam int PW = 2 * DATA_W;
	localparam int XW = PW + 2;
	localparam logic [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	data_t                 a [3];
	data_t                 b [3];
	data_t                 mx [3];
	data_t                 my [3];
	logic signed [PW-1:0]  prod [6];

	logic                  valid_s1;
	logic [OPC_W-1:0]      op_s1;
	data_t                 a_s1 [3];
	data_t                 b_s1 [3];
	data_t                 s_s1;
	logic signed [PW-1:0]  p_s1 [6];

	logic signed [XW-1:0]  psum;
	logic signed [XW-1:0]  xv [3];
	logic                  rnd [3];
	data_t                 dsrc [3];
	logic                  dneg [3];
	logic [DATA_W-1:0]     dmag [3];

	logic                  valid_s2;
	logic signed [XW-1:0]  x_s2 [3];
	logic                  rnd_s2 [3];
	logic                  dneg_s2 [3];
	logic [DATA_W-1:0]     dmag_s2 [3];
	logic                  div_s2;
	logic                  norm_s2;
	logic                  smag_s2;
	logic                  vec_s2;
	logic                  scl_s2;
	logic signed [XW-1:0]  scx_s2;
	logic [PW-1:0]         sumsq_s2;

	item_t                 item_d;
	logic                  valid_s3;
	item_t                 item_s3;
	logic [PW-1:0]         sumsq_s3;

	function automatic logic [MAG_W:0] to_sm(input logic signed [XW-1:0] x, input logic r);
		logic          neg;
		logic [XW-1:0] m;
		neg = x[XW-1];
		m = (neg ? ~x : x) + XW'(neg) + (r ? HALF : '0);
		if (r) begin
			m = m >> FRAC_BITS;
		end
		return {neg, m[MAG_W-1:0]};
	endfunction

	assign a[0] = cmd.a_x;
	assign a[1] = cmd.a_y;
	assign a[2] = cmd.a_z;
	assign b[0] = cmd.b_x;
	assign b[1] = cmd.b_y;
	assign b[2] = cmd.b_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mx[i] = a[i];
			my[i] = b[i];
			case (cmd.opcode)
				OP_SCALE: begin
					my[i] = cmd.scalar_in;
				end
				OP_MAG, OP_NORM: begin
					my[i] = a[i];
				end
				OP_CROSS: begin
					mx[i] = a[NXT[i]];
					my[i] = b[PRV[i]];
				end
				default: ;
			endcase
			prod[i]     = mx[i] * my[i];
			prod[i + 3] = a[PRV[i]] * b[NXT[i]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= cmd.opcode;
		s_s1  <= cmd.scalar_in;
		for (int i = 0; i < 3; i++) begin
			a_s1[i] <= a[i];
			b_s1[i] <= b[i];
		end
		for (int i = 0; i < 6; i++) begin
			p_s1[i] <= prod[i];
		end
	end

	always_comb begin
		psum = XW'(p_s1[0]) + XW'(p_s1[1]) + XW'(p_s1[2]);
		for (int i = 0; i < 3; i++) begin
			xv[i]   = '0;
			rnd[i]  = 1'b0;
			dsrc[i] = (op_s1 == OP_DIVS) ? s_s1 : b_s1[i];
			dneg[i] = dsrc[i][DATA_W-1];
			dmag[i] = dneg[i] ? (~dsrc[i] + 1'b1) : dsrc[i];
			case (op_s1)
				OP_NEG: begin
					xv[i] = -XW'(a_s1[i]);
				end
				OP_ADD: begin
					xv[i] = XW'(a_s1[i]) + XW'(b_s1[i]);
				end
				OP_SUB: begin
					xv[i] = XW'(a_s1[i]) - XW'(b_s1[i]);
				end
				OP_MUL, OP_SCALE: begin
					xv[i]  = XW'(p_s1[i]);
					rnd[i] = 1'b1;
				end
				OP_DIV, OP_DIVS, OP_NORM: begin
					xv[i] = XW'(a_s1[i]);
				end
				OP_CROSS: begin
					xv[i]  = XW'(p_s1[i]) - XW'(p_s1[i + 3]);
					rnd[i] = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			x_s2[i]    <= xv[i];
			rnd_s2[i]  <= rnd[i];
			dneg_s2[i] <= dneg[i];
			dmag_s2[i] <= dmag[i];
		end
		div_s2   <= (op_s1 == OP_DIV) || (op_s1 == OP_DIVS) || (op_s1 == OP_NORM);
		norm_s2  <= (op_s1 == OP_NORM);
		smag_s2  <= (op_s1 == OP_MAG);
		vec_s2   <= (op_s1 <= OP_DIVS) || (op_s1 == OP_NORM) || (op_s1 == OP_CROSS);
		scl_s2   <= (op_s1 == OP_MAG) || (op_s1 == OP_DOT);
		scx_s2   <= (op_s1 == OP_DOT) ? psum : '0;
		sumsq_s2 <= psum[PW-1:0];
	end

	always_comb begin
		logic [MAG_W:0] sm;
		item_d = '0;
		for (int i = 0; i < 3; i++) begin
			sm = to_sm(x_s2[i], rnd_s2[i]);
			item_d.lane[i].neg     = sm[MAG_W];
			item_d.lane[i].mag     = sm[MAG_W-1:0];
			item_d.lane[i].div     = div_s2;
			item_d.lane[i].dz      = 1'b0;
			item_d.lane[i].dvs_neg = dneg_s2[i];
			item_d.lane[i].dvs_mag = dmag_s2[i];
		end
		sm = to_sm(scx_s2, 1'b1);
		item_d.ctl.norm   = norm_s2;
		item_d.ctl.smag   = smag_s2;
		item_d.ctl.vec    = vec_s2;
		item_d.ctl.scl    = scl_s2;
		item_d.ctl.sc_neg = sm[MAG_W];
		item_d.ctl.sc_mag = sm[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s3  <= item_d;
		sumsq_s3 <= sumsq_s2;
	end

	assign out_valid = valid_s3;
	assign item      = item_s3;
	assign sumsq     = sumsq_s3;

endmodule

@@ rtl/vva_sqrt.sv @@
// ----------------------------------------------------------------------------
// vva_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vva_sqrt import vva_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [2*DATA_W-1:0] rad,
	input  item_t               item_in,
	output logic                out_valid,
	output logic [DATA_W-1:0]   root,
	output item_t               item_out
);

	localparam int RW = DATA_W + 2;

	logic                valid_s [1:DATA_W];
	logic [2*DATA_W-1:0] rad_s   [1:DATA_W];
	logic [RW-1:0]       rem_s   [1:DATA_W];
	logic [DATA_W-1:0]   root_s  [1:DATA_W];
	item_t               item_s  [1:DATA_W];

	for (genvar k = 0; k < DATA_W; k++) begin : g_stg
		logic                cv;
		logic [2*DATA_W-1:0] crad;
		logic [RW-1:0]       crem;
		logic [DATA_W-1:0]   croot;
		item_t               citem;
		logic [RW+1:0]       rsh;
		logic [RW+1:0]       trial;
		logic                ge;

		if (k == 0) begin : g_src
			always_comb begin
				cv    = in_valid;
				crad  = rad;
				crem  = '0;
				croot = '0;
				citem = item_in;
			end
		end else begin : g_src
			always_comb begin
				cv    = valid_s[k];
				crad  = rad_s[k];
				crem  = rem_s[k];
				croot = root_s[k];
				citem = item_s[k];
			end
		end

		always_comb begin
			rsh   = {crem, crad[2*DATA_W-1 -: 2]};
			trial = {RW'(croot), 2'b01};
			ge    = rsh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			rad_s[k+1]  <= crad << 2;
			item_s[k+1] <= citem;
			if (ge) begin
				rem_s[k+1]  <= RW'(rsh - trial);
				root_s[k+1] <= {croot[DATA_W-2:0], 1'b1};
			end else begin
				rem_s[k+1]  <= RW'(rsh);
				root_s[k+1] <= {croot[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign out_valid = valid_s[DATA_W];
	assign root      = root_s[DATA_W];
	assign item_out  = item_s[DATA_W];

endmodule

@@ rtl/vva_div.sv @@
// ----------------------------------------------------------------------------
// vva_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Also places the root into the magnitude and normalize paths.
// ----------------------------------------------------------------------------
module vva_div import vva_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  item_t             item_in,
	input  logic [DATA_W-1:0] root,
	output logic              out_valid,
	output item_t             item_out
);

	localparam int NW = DATA_W + FRAC_BITS;

	item_t             it0;
	logic [NW-1:0]     n0 [3];

	logic              valid_s [1:NW];
	item_t             item_s  [1:NW];
	logic [NW-1:0]     num_s   [1:NW][3];
	logic [NW-1:0]     q_s     [1:NW][3];
	logic [DATA_W-1:0] rem_s   [1:NW][3];

	always_comb begin
		it0 = item_in;
		if (item_in.ctl.smag) begin
			it0.ctl.sc_neg = 1'b0;
			it0.ctl.sc_mag = MAG_W'(root);
		end
		for (int i = 0; i < 3; i++) begin
			if (item_in.ctl.norm) begin
				it0.lane[i].dvs_neg = 1'b0;
				it0.lane[i].dvs_mag = root;
			end
			n0[i] = (NW'(it0.lane[i].mag[DATA_W-1:0]) << FRAC_BITS)
				+ NW'(it0.lane[i].dvs_mag >> 1);
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_stg
		logic              cv;
		item_t             ci;
		logic [NW-1:0]     cn [3];
		logic [NW-1:0]     cq [3];
		logic [DATA_W-1:0] cr [3];
		logic [DATA_W:0]   rsh [3];
		logic              ge [3];

		if (k == 0) begin : g_src
			always_comb begin
				cv = in_valid;
				ci = it0;
				for (int i = 0; i < 3; i++) begin
					cn[i] = n0[i];
					cq[i] = '0;
					cr[i] = '0;
				end
			end
		end else begin : g_src
			always_comb begin
				cv = valid_s[k];
				ci = item_s[k];
				for (int i = 0; i < 3; i++) begin
					cn[i] = num_s[k][i];
					cq[i] = q_s[k][i];
					cr[i] = rem_s[k][i];
				end
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				rsh[i] = {cr[i], cn[i][NW-1]};
				ge[i]  = rsh[i] >= {1'b0, ci.lane[i].dvs_mag};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			item_s[k+1] <= ci;
			for (int i = 0; i < 3; i++) begin
				num_s[k+1][i] <= cn[i] << 1;
				q_s[k+1][i]   <= {cq[i][NW-2:0], ge[i]};
				if (ge[i]) begin
					rem_s[k+1][i] <= DATA_W'(rsh[i] - {1'b0, ci.lane[i].dvs_mag});
				end else begin
					rem_s[k+1][i] <= DATA_W'(rsh[i]);
				end
			end
		end
	end

	// zero divisor: limit of the dividend's sign, or zero for a zero dividend
	always_comb begin
		item_out = item_s[NW];
		for (int i = 0; i < 3; i++) begin
			if (item_s[NW].lane[i].div) begin
				if (item_s[NW].lane[i].dvs_mag == '0) begin
					item_out.lane[i].dz  = 1'b1;
					item_out.lane[i].mag = (item_s[NW].lane[i].mag == '0) ? '0 : '1;
				end else begin
					item_out.lane[i].neg = item_s[NW].lane[i].neg ^ item_s[NW].lane[i].dvs_neg;
					item_out.lane[i].mag = MAG_W'(q_s[NW][i]);
				end
			end
		end
	end

	assign out_valid = valid_s[NW];

endmodule

@@ rtl/vva_out.sv @@
// ----------------------------------------------------------------------------
// vva_out
// Saturation, sign restore, output select and status; registered result.
// ----------------------------------------------------------------------------
module vva_out import vva_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  item_t item,
	output logic  done,
	output res_t  res
);

	logic  done_q;
	res_t  res_q;
	res_t  res_d;

	function automatic logic [DATA_W:0] emit(input logic neg, input logic [MAG_W-1:0] mag);
		logic [MAG_W-1:0]  lim;
		logic              sat;
		logic [DATA_W-1:0] m;
		lim = neg ? (MAG_W'(1) << (DATA_W - 1)) : ((MAG_W'(1) << (DATA_W - 1)) - 1'b1);
		sat = mag > lim;
		m   = sat ? lim[DATA_W-1:0] : mag[DATA_W-1:0];
		return {sat, neg ? (~m + 1'b1) : m};
	endfunction

	always_comb begin
		logic [DATA_W:0] e [3];
		logic [DATA_W:0] es;
		logic            sat;
		logic            dz;
		for (int i = 0; i < 3; i++) begin
			e[i] = emit(item.lane[i].neg, item.lane[i].mag);
		end
		es  = emit(item.ctl.sc_neg, item.ctl.sc_mag);
		sat = (item.ctl.vec && (e[0][DATA_W] || e[1][DATA_W] || e[2][DATA_W]))
			|| (item.ctl.scl && es[DATA_W]);
		dz  = item.ctl.vec && (item.lane[0].dz || item.lane[1].dz || item.lane[2].dz);
		res_d.r_x        = item.ctl.vec ? e[0][DATA_W-1:0] : '0;
		res_d.r_y        = item.ctl.vec ? e[1][DATA_W-1:0] : '0;
		res_d.r_z        = item.ctl.vec ? e[2][DATA_W-1:0] : '0;
		res_d.scalar_out = item.ctl.scl ? es[DATA_W-1:0] : '0;
		res_d.status     = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

@@ rtl/vec3_vector_alu.sv @@
// ----------------------------------------------------------------------------
// vec3_vector_alu
// Pipelined ALU for three-component Q16.16 vectors: arithmetic, divide,
// magnitude, normalize, dot and cross product with saturation.
//
//   port    dir  word     handshake
//   cmd     in   cmd_t    taken on clk when start && !busy
//   res     out  res_t    valid for the one cycle that done is high
//
// One word per cycle; the pipeline holds three front stages, one
// square-root stage per root bit, one divider stage per quotient bit
// and one output register, for Q16.16 words.
// busy stays low; the pipeline never stalls and results are not held.
// arst_n clears all valid bits; words in flight are dropped.
// ----------------------------------------------------------------------------
module vec3_vector_alu import vva_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic done,
	output res_t res
);

	logic                fr_valid;
	item_t               fr_item;
	logic [2*DATA_W-1:0] fr_sumsq;
	logic                sq_valid;
	logic [DATA_W-1:0]   sq_root;
	item_t               sq_item;
	logic                dv_valid;
	item_t               dv_item;

	assign busy = 1'b0;

	vva_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.cmd       (cmd),
		.out_valid (fr_valid),
		.item      (fr_item),
		.sumsq     (fr_sumsq)
	);

	vva_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.rad       (fr_sumsq),
		.item_in   (fr_item),
		.out_valid (sq_valid),
		.root      (sq_root),
		.item_out  (sq_item)
	);

	vva_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.item_in   (sq_item),
		.root      (sq_root),
		.out_valid (dv_valid),
		.item_out  (dv_item)
	);

	vva_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv_valid),
		.item     (dv_item),
		.done     (done),
		.res      (res)
	);

endmodule

@@ rtl/vva_chk.sv @@
// ----------------------------------------------------------------------------
// vva_chk
// Port-level checks for the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
module vva_chk import vva_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input res_t res
);

	localparam int LAT = FRONT_STAGES + 1 + 2 * DATA_W + FRAC_BITS;

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result word without a matching command word");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(cmd.opcode, LAT) > OP_CROSS) |-> res == '0)
		else $error("unused opcode gave a nonzero result");

	a_scalar_vec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && ($past(cmd.opcode, LAT) == OP_MAG || $past(cmd.opcode, LAT) == OP_DOT)
		|-> res.r_x == '0 && res.r_y == '0 && res.r_z == '0)
		else $error("scalar op gave a nonzero vector");

	a_dz_only_div: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status == ST_DZ
		|-> $past(cmd.opcode, LAT) == OP_DIV || $past(cmd.opcode, LAT) == OP_DIVS
			|| $past(cmd.opcode, LAT) == OP_NORM)
		else $error("divide-by-zero status on a non-divide op");

endmodule

bind vec3_vector_alu vva_chk #(.FRAC_BITS(FRAC_BITS)) u_vva_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.res    (res)
);
